@@ hdl/pwc_pkg.sv @@
package pwc_pkg;

	localparam int SIDE_DEF       = 128;
	localparam int MAX_STATES_DEF = 16;

	localparam int SEED_W   = 14;
	localparam int SHIFT_W  = 4;
	localparam int SPIN_W   = 4;
	localparam int OUT_W    = 15;
	localparam int WORD_W   = 32;
	localparam int NSTATE_W = 5;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADD_THRESHOLD = 2'd0,
		CFG_RNG_SEED      = 2'd1,
		CFG_NUM_STATES    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [SEED_W-1:0]  seed_site;
		logic [SHIFT_W-1:0] state_shift;
	} pwc_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] flip_count;
		logic [OUT_W-1:0] max_state_count;
	} pwc_res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_SEED_RD,
		ST_SEED_EV,
		ST_MOD,
		ST_POP,
		ST_POP_WT,
		ST_NB_RD,
		ST_NB_EV,
		ST_CNT_OLD,
		ST_CNT_NEW,
		ST_SCAN,
		ST_DONE
	} pwc_state_t;

	// xorshift32, shifts 13/17/5
	function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

@@ hdl/pwc_div.sv @@
// division of a seed-width value by SIDE through a reciprocal multiply;
// done rises in the cycle after start
module pwc_div #(
	parameter int SIDE = pwc_pkg::SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pwc_pkg::SEED_W-1:0]  dividend,
	output logic                        done,
	output logic [pwc_pkg::SEED_W-1:0]  quot,
	output logic [$clog2(SIDE)-1:0]     rem
);
	import pwc_pkg::*;

	localparam int RC_W   = $clog2(SIDE);
	localparam int SH     = SEED_W + RC_W;
	localparam int MUL_W  = SEED_W + 2;
	localparam int PROD_W = SEED_W + MUL_W;
	// ceil(2^SH / SIDE): exact quotient for every SEED_W-bit dividend
	localparam logic [MUL_W-1:0] RECIP =
		MUL_W'(((longint'(1) << SH) + longint'(SIDE) - 1) / longint'(SIDE));

	logic [SEED_W-1:0] num_q;
	logic [SEED_W-1:0] quot_q;
	logic              done_q;
	logic [PROD_W-1:0] prod;
	logic [SEED_W-1:0] back;

	assign prod = PROD_W'(dividend) * PROD_W'(RECIP);
	assign back = SEED_W'(quot_q * SEED_W'(SIDE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			quot_q <= SEED_W'(prod >> SH);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = RC_W'(num_q - back);

endmodule

@@ hdl/pwc_spin_mem.sv @@
// spin store: one write, one registered read; swept to zero after reset
module pwc_spin_mem #(
	parameter int DEPTH = pwc_pkg::SIDE_DEF * pwc_pkg::SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [pwc_pkg::SPIN_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [pwc_pkg::SPIN_W-1:0]  rdata,
	output logic                        clearing
);
	import pwc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [SPIN_W-1:0] mem [DEPTH];
	logic [AW-1:0]     clr_idx_q;
	logic              clearing_q;
	logic [SPIN_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_idx_q] <= '0;
		else if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

@@ hdl/pwc_fifo.sv @@
// cluster frontier queue; emptied at the start of each update
module pwc_fifo #(
	parameter int DEPTH = pwc_pkg::SIDE_DEF * pwc_pkg::SIDE_DEF,
	parameter int W     = 2 * $clog2(pwc_pkg::SIDE_DEF)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clr,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [CW-1:0] head_q;
	logic [CW-1:0] tail_q;
	logic [W-1:0]  rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (clr) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push)
				tail_q <= tail_q + 1'b1;
			if (pop)
				head_q <= head_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[tail_q[AW-1:0]] <= wdata;
		rdata_q <= mem[head_q[AW-1:0]];
	end

	assign rdata = rdata_q;
	assign empty = head_q == tail_q;
	assign full  = tail_q == CW'(DEPTH);

endmodule

@@ hdl/potts_wolff_cluster_update.sv @@
// Wolff cluster update for a q-state Potts model on a periodic SIDE x SIDE
// brick-wall honeycomb lattice.
// Request channel: drive request (seed_site, state_shift) with start; it is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been shown; the next request goes in the cycle after.
// Result: done pulses for exactly one cycle with result (flip_count,
// max_state_count). The receiver cannot stall; it must take it then.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while busy is low. Index 0 add_threshold, 1 rng_seed
// (loads the generator, zero loads one), 2 num_states; index 3 is ignored.
// Work from accept to done: two reciprocal divisions by SIDE for column and
// row, seed read, repeated subtraction to wrap the new spin mod q, then per
// cluster site one queue read and three neighbor read/evaluate/write-back
// passes on the spin store, then the count update and a scan of all
// MAX_STATES counts for the largest one.
// A request with an out-of-range shift goes straight to the scan.
// Reset: the spin store is swept to zero, one site per cycle, all SIDE*SIDE
// sites; busy is high during the sweep.
module potts_wolff_cluster_update #(
	parameter int SIDE       = pwc_pkg::SIDE_DEF,
	parameter int MAX_STATES = pwc_pkg::MAX_STATES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pwc_pkg::pwc_req_t              request,
	output logic                           done,
	output pwc_pkg::pwc_res_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwc_pkg::WORD_W-1:0]     cfg_data
);
	import pwc_pkg::*;

	localparam int NUM_SITES = SIDE * SIDE;
	localparam int RC_W      = $clog2(SIDE);
	localparam int SITE_W    = $clog2(NUM_SITES);
	localparam int CNT_W     = $clog2(NUM_SITES + 1);
	localparam int CIDX_W    = $clog2(MAX_STATES);
	localparam int FW        = 2 * RC_W;

	function automatic logic [SITE_W-1:0] site_addr(input logic [RC_W-1:0] r,
		input logic [RC_W-1:0] c);
		return SITE_W'(int'(r) * SIDE + int'(c));
	endfunction

	// config registers
	logic [WORD_W-1:0]   thr_q;
	logic [WORD_W-1:0]   rng_q;
	logic [NSTATE_W-1:0] nstates_q;

	pwc_state_t state_q, state_d;

	// per-request datapath
	logic [SHIFT_W-1:0]  shift_q;
	logic [NSTATE_W-1:0] q_q;
	logic [RC_W-1:0]     row_q, col_q;
	logic [SPIN_W-1:0]   old_q, new_q;
	logic [NSTATE_W-1:0] sum_q;
	logic [RC_W-1:0]     cur_r_q, cur_c_q;
	logic [RC_W-1:0]     nb_r_q, nb_c_q;
	logic [1:0]          nb_idx_q;
	logic [CNT_W-1:0]    size_q;
	logic [CIDX_W-1:0]   scan_idx_q;
	logic [CNT_W-1:0]    best_q;
	logic [CNT_W-1:0]    counts_q [MAX_STATES];

	// clamped q and shift check at accept
	logic [NSTATE_W-1:0] q_eff;
	logic                shift_ok;
	logic                accept;

	// divider
	logic                div_start, div_done;
	logic [SEED_W-1:0]   div_in, div_quot;
	logic [RC_W-1:0]     div_rem;

	// spin store
	logic                sp_we, sp_clearing;
	logic [SITE_W-1:0]   sp_waddr, sp_raddr;
	logic [SPIN_W-1:0]   sp_wdata, sp_rdata;

	// queue
	logic                fq_clr, fq_push, fq_pop, fq_empty, fq_full;
	logic [FW-1:0]       fq_wdata, fq_rdata;

	// neighbor selection
	logic [RC_W-1:0]     r_up, r_dn, c_lf, c_rt, nr, nc;
	logic [WORD_W-1:0]   draw;
	logic                joins;

	always_comb begin
		if (nstates_q < NSTATE_W'(2))
			q_eff = NSTATE_W'(2);
		else if (nstates_q > NSTATE_W'(MAX_STATES))
			q_eff = NSTATE_W'(MAX_STATES);
		else
			q_eff = nstates_q;
	end

	assign shift_ok  = (request.state_shift != '0) &&
		(NSTATE_W'(request.state_shift) < q_eff);
	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;

	// lattice neighbors of the current site, with wrap
	assign r_up = (cur_r_q == RC_W'(SIDE - 1)) ? '0 : cur_r_q + 1'b1;
	assign r_dn = (cur_r_q == '0) ? RC_W'(SIDE - 1) : cur_r_q - 1'b1;
	assign c_lf = (cur_c_q == '0) ? RC_W'(SIDE - 1) : cur_c_q - 1'b1;
	assign c_rt = (cur_c_q == RC_W'(SIDE - 1)) ? '0 : cur_c_q + 1'b1;

	always_comb begin
		case (nb_idx_q)
			2'd0: begin
				nr = r_up;
				nc = cur_c_q;
			end
			2'd1: begin
				nr = r_dn;
				nc = cur_c_q;
			end
			default: begin
				nr = cur_r_q;
				nc = (cur_r_q[0] ^ cur_c_q[0]) ? c_rt : c_lf;
			end
		endcase
	end

	assign draw  = xorshift32(rng_q);
	assign joins = (sp_rdata == old_q) && (draw < thr_q) && !fq_full;

	pwc_div #(.SIDE(SIDE)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	pwc_spin_mem #(.DEPTH(NUM_SITES)) u_spin (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (sp_we),
		.waddr    (sp_waddr),
		.wdata    (sp_wdata),
		.raddr    (sp_raddr),
		.rdata    (sp_rdata),
		.clearing (sp_clearing)
	);

	pwc_fifo #(.DEPTH(NUM_SITES), .W(FW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (fq_clr),
		.push   (fq_push),
		.wdata  (fq_wdata),
		.pop    (fq_pop),
		.rdata  (fq_rdata),
		.empty  (fq_empty),
		.full   (fq_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_in    = request.seed_site;
		sp_we     = 1'b0;
		sp_waddr  = site_addr(nb_r_q, nb_c_q);
		sp_wdata  = new_q;
		sp_raddr  = site_addr(nr, nc);
		fq_clr    = 1'b0;
		fq_push   = 1'b0;
		fq_wdata  = {nb_r_q, nb_c_q};
		fq_pop    = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (!sp_clearing)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					fq_clr = 1'b1;
					if (shift_ok) begin
						div_start = 1'b1;
						state_d   = ST_DIV1;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_DIV1: begin
				if (div_done) begin
					div_start = 1'b1;
					div_in    = div_quot;
					state_d   = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (div_done)
					state_d = ST_SEED_RD;
			end
			ST_SEED_RD: begin
				sp_raddr = site_addr(row_q, col_q);
				state_d  = ST_SEED_EV;
			end
			ST_SEED_EV: state_d = ST_MOD;
			ST_MOD: begin
				if (sum_q < q_q) begin
					sp_we    = 1'b1;
					sp_waddr = site_addr(row_q, col_q);
					sp_wdata = sum_q[SPIN_W-1:0];
					fq_push  = 1'b1;
					fq_wdata = {row_q, col_q};
					state_d  = ST_POP;
				end
			end
			ST_POP: begin
				if (fq_empty) begin
					state_d = ST_CNT_OLD;
				end else begin
					fq_pop  = 1'b1;
					state_d = ST_POP_WT;
				end
			end
			ST_POP_WT: state_d = ST_NB_RD;
			ST_NB_RD: state_d = ST_NB_EV;
			ST_NB_EV: begin
				if (joins) begin
					sp_we   = 1'b1;
					fq_push = 1'b1;
				end
				state_d = (nb_idx_q == 2'd2) ? ST_POP : ST_NB_RD;
			end
			ST_CNT_OLD: state_d = ST_CNT_NEW;
			ST_CNT_NEW: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_idx_q == CIDX_W'(MAX_STATES - 1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// config registers and generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			rng_q     <= WORD_W'(1);
			nstates_q <= NSTATE_W'(4);
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ADD_THRESHOLD: thr_q <= cfg_data;
					CFG_RNG_SEED:      rng_q <= (cfg_data == '0) ? WORD_W'(1) : cfg_data;
					CFG_NUM_STATES:    nstates_q <= cfg_data[NSTATE_W-1:0];
					default: ;
				endcase
			end
			// one draw per neighbor that holds the old spin
			if (state_q == ST_NB_EV && sp_rdata == old_q)
				rng_q <= draw;
		end
	end

	// per-state counts; reset puts every site in state zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_STATES; k++)
				counts_q[k] <= (k == 0) ? CNT_W'(NUM_SITES) : '0;
		end else if (state_q == ST_CNT_OLD) begin
			counts_q[old_q[CIDX_W-1:0]] <= counts_q[old_q[CIDX_W-1:0]] - size_q;
		end else if (state_q == ST_CNT_NEW) begin
			counts_q[new_q[CIDX_W-1:0]] <= counts_q[new_q[CIDX_W-1:0]] + size_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				shift_q    <= request.state_shift;
				q_q        <= q_eff;
				size_q     <= '0;
				best_q     <= '0;
				scan_idx_q <= '0;
			end
			ST_DIV1: if (div_done) col_q <= div_rem;
			ST_DIV2: if (div_done) row_q <= div_rem;
			ST_SEED_EV: begin
				old_q <= sp_rdata;
				sum_q <= NSTATE_W'(sp_rdata) + NSTATE_W'(shift_q);
			end
			ST_MOD: begin
				if (sum_q < q_q) begin
					new_q  <= sum_q[SPIN_W-1:0];
					size_q <= CNT_W'(1);
				end else begin
					sum_q <= sum_q - q_q;
				end
			end
			ST_POP_WT: begin
				cur_r_q  <= fq_rdata[FW-1:RC_W];
				cur_c_q  <= fq_rdata[RC_W-1:0];
				nb_idx_q <= 2'd0;
			end
			ST_NB_RD: begin
				nb_r_q <= nr;
				nb_c_q <= nc;
			end
			ST_NB_EV: begin
				nb_idx_q <= nb_idx_q + 1'b1;
				if (joins)
					size_q <= size_q + 1'b1;
			end
			ST_SCAN: begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (counts_q[scan_idx_q] > best_q)
					best_q <= counts_q[scan_idx_q];
			end
			default: ;
		endcase
	end

	assign result.flip_count      = OUT_W'(size_q);
	assign result.max_state_count = OUT_W'(best_q);

endmodule

@@ hdl/pwc_checker.sv @@
module pwc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              cfg_ready
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while not busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request taken but busy low");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("result strobe longer than a cycle");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("config channel not ready");

endmodule

bind potts_wolff_cluster_update pwc_checker u_pwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);
